// ===== hw/rtl/probed_hash_cache_lru_core_macros.svh =====
// assertion macros for the probed hash cache core
`ifndef PROBED_HASH_CACHE_LRU_CORE_MACROS_SVH
`define PROBED_HASH_CACHE_LRU_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PHC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define PHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define PHC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PHC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/phc_pkg.sv =====
// shared types and constants for the probed hash cache core
`timescale 1ns / 1ps
package phc_pkg;
	localparam int KEY_BITS = 64;
	localparam int AGE_BITS = 64;
	localparam int VAL_BITS = 32;
	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_SET = 1'b1;
	typedef struct packed {
		logic                action;
		logic [KEY_BITS-1:0] key;
		logic [VAL_BITS-1:0] wval;
	} req_t;
endpackage

// ===== hw/rtl/probed_hash_cache_lru_core.sv =====
// top level of the probed hash cache core
`timescale 1ns / 1ps
// usage:
// command channel: pulse start with action, key, write_value while busy is low;
// the beat is taken when start is high and busy is low.
// result channel: done strobes for one cycle with hit, read_value, evicted,
// evicted_key, evicted_value; the receiver cannot stall, results must be taken.
// a two-entry queue sits between the command front and the probe engine, so
// commands can be taken while the engine works.
// each command probes up to PROBE_LIMIT slots in the slot memory (one read port),
// each slot with a read state and a check state, then the output state; a set
// that finds every probed slot valid first rereads the oldest one as the victim.
// throughput is bound by the probe loop on the single memory read port.
// after reset the engine clears the valid bits of all 2^INDEX_BITS slots, one
// slot a cycle; commands queue meanwhile (two, then busy).
// the age counter resets to zero.
module probed_hash_cache_lru_core import phc_pkg::*; #(
	parameter int INDEX_BITS = 10,
	parameter int PROBE_LIMIT = 8,
	parameter int DATA_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic action,
	input  logic [KEY_BITS-1:0] key,
	input  logic [VAL_BITS-1:0] write_value,
	output logic done,
	output logic hit,
	output logic [VAL_BITS-1:0] read_value,
	output logic evicted,
	output logic [KEY_BITS-1:0] evicted_key,
	output logic [VAL_BITS-1:0] evicted_value
);
	logic q_valid, q_pop;
	req_t q_req;

	phc_front u_front (
		.clk, .arst_n, .start, .busy, .action, .key, .write_value,
		.q_valid, .q_req, .q_pop
	);

	phc_engine #(
		.INDEX_BITS(INDEX_BITS), .PROBE_LIMIT(PROBE_LIMIT), .DATA_BITS(DATA_BITS)
	) u_engine (
		.clk, .arst_n, .q_valid, .q_req, .q_pop, .done, .hit, .read_value,
		.evicted, .evicted_key, .evicted_value
	);
endmodule

// ===== hw/rtl/phc_front.sv =====
// front part: takes commands and queues them for the probe engine
`timescale 1ns / 1ps
`include "probed_hash_cache_lru_core_macros.svh"
module phc_front import phc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic action,
	input  logic [KEY_BITS-1:0] key,
	input  logic [VAL_BITS-1:0] write_value,
	output logic q_valid,
	output req_t q_req,
	input  logic q_pop
);
	req_t ent_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push;

	assign busy = cnt_q[1];
	assign push = start && !busy;
	assign q_valid = cnt_q != 2'd0;
	assign q_req = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= '{action: action, key: key, wval: write_value};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	`PHC_ASSERT_IMPL(a_pop_nonempty, clk, arst_n, q_pop, cnt_q != 2'd0)
	`PHC_ASSERT_IMPL(a_cnt_range, clk, arst_n, 1'b1, cnt_q != 2'd3)
	`PHC_ASSERT_NEXT(a_full_busy, clk, arst_n, push && !q_pop && cnt_q == 2'd1, busy)
endmodule

// ===== hw/rtl/phc_engine.sv =====
// back part: probes the slot memory, updates ages and reports results
`timescale 1ns / 1ps
`include "probed_hash_cache_lru_core_macros.svh"
module phc_engine import phc_pkg::*; #(
	parameter int INDEX_BITS = 10,
	parameter int PROBE_LIMIT = 8,
	parameter int DATA_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  req_t q_req,
	output logic q_pop,
	output logic done,
	output logic hit,
	output logic [VAL_BITS-1:0] read_value,
	output logic evicted,
	output logic [KEY_BITS-1:0] evicted_key,
	output logic [VAL_BITS-1:0] evicted_value
);
	localparam int DEPTH = 1 << INDEX_BITS;
	localparam int PB = $clog2(PROBE_LIMIT + 1);
	// stored data never exceeds the width of the value port
	localparam int DB = (DATA_BITS < VAL_BITS) ? DATA_BITS : VAL_BITS;
	localparam logic [2:0] ST_IDLE = 3'd0, ST_CLR = 3'd1, ST_RD = 3'd2,
		ST_CHK = 3'd3, ST_WR = 3'd4, ST_OUT = 3'd5;

	logic [KEY_BITS-1:0]  key_mem [DEPTH];
	logic [AGE_BITS-1:0]  age_mem [DEPTH];
	logic [DB-1:0]        dat_mem [DEPTH];
	logic                 vld_mem [DEPTH];

	logic [2:0] st_q;
	logic [INDEX_BITS-1:0] idx_q, ci_q, vic_q;
	logic [INDEX_BITS:0] clr_q;
	logic [PB-1:0] n_q;
	req_t req_q;
	logic [AGE_BITS-1:0] ctr_q, old_q;
	logic [KEY_BITS-1:0] rk_q;
	logic [AGE_BITS-1:0] ra_q;
	logic [DB-1:0] rd_q;
	logic rv_q;
	logic wr_q, wfull_q, whit_q;
	logic [INDEX_BITS-1:0] wi_q;
	logic [AGE_BITS-1:0] wa_q;
	logic hit_q, ev_q;
	logic [VAL_BITS-1:0] rval_q, evv_q;
	logic [KEY_BITS-1:0] evk_q;
	logic [VAL_BITS-1:0] rd_ext;

	assign q_pop = st_q == ST_IDLE && q_valid;
	assign done = st_q == ST_OUT;
	assign hit = hit_q;
	assign read_value = rval_q;
	assign evicted = ev_q;
	assign evicted_key = evk_q;
	assign evicted_value = evv_q;

	always_comb begin
		rd_ext = '0;
		rd_ext[DB-1:0] = rd_q;
	end

	// memory ports: one read, one write a cycle
	always_ff @(posedge clk) begin
		rk_q <= key_mem[idx_q];
		ra_q <= age_mem[idx_q];
		rd_q <= dat_mem[idx_q];
		rv_q <= vld_mem[idx_q];
		if (st_q == ST_CLR) vld_mem[clr_q[INDEX_BITS-1:0]] <= 1'b0;
		else if (wr_q) begin
			age_mem[wi_q] <= wa_q;
			if (!whit_q) begin
				vld_mem[wi_q] <= 1'b1;
				key_mem[wi_q] <= req_q.key;
				dat_mem[wi_q] <= req_q.wval[DB-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR;
			clr_q <= '0;
			ctr_q <= '0;
			wr_q <= 1'b0;
			idx_q <= '0;
		end else begin
			wr_q <= 1'b0;
			case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (INDEX_BITS+1)'(DEPTH - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: if (q_valid) begin
					req_q <= q_req;
					idx_q <= q_req.key[INDEX_BITS-1:0];
					n_q <= '0;
					hit_q <= 1'b0; ev_q <= 1'b0;
					rval_q <= '0; evk_q <= '0; evv_q <= '0;
					st_q <= ST_RD;
				end
				ST_RD: begin
					ci_q <= idx_q;
					st_q <= ST_CHK;
				end
				ST_CHK: begin
					st_q <= ST_RD;
					idx_q <= idx_q + 1'b1;
					n_q <= n_q + 1'b1;
					if (req_q.action == ACT_GET) begin
						if (rv_q && rk_q == req_q.key) begin
							hit_q <= 1'b1;
							rval_q <= rd_ext;
							wi_q <= ci_q; wa_q <= ctr_q + 1'b1; whit_q <= 1'b1;
							wr_q <= 1'b1;
							ctr_q <= ctr_q + 1'b1;
							st_q <= ST_OUT;
						end else if (n_q == PB'(PROBE_LIMIT - 1)) st_q <= ST_OUT;
					end else begin
						if (!rv_q) begin
							wi_q <= ci_q; wa_q <= ctr_q; whit_q <= 1'b0;
							wr_q <= 1'b1; ctr_q <= ctr_q + 1'b1;
							st_q <= ST_OUT;
						end else begin
							if (n_q == '0 || ra_q < old_q) begin
								old_q <= ra_q; vic_q <= ci_q;
							end
							if (n_q == PB'(PROBE_LIMIT - 1)) begin
								idx_q <= (n_q == '0 || ra_q < old_q) ? ci_q : vic_q;
								st_q <= ST_WR;
							end
						end
					end
				end
				ST_WR: begin
					// victim address was set in ST_CHK; wait here for its registered read data
					ci_q <= idx_q;
					st_q <= ST_WR + 3'd0;
					if (ci_q == idx_q && n_q == '0) begin
						ev_q <= 1'b1; evk_q <= rk_q; evv_q <= rd_ext;
						wi_q <= idx_q; wa_q <= ctr_q; whit_q <= 1'b0;
						wr_q <= 1'b1; ctr_q <= ctr_q + 1'b1;
						st_q <= ST_OUT;
					end
					n_q <= '0;
				end
				ST_OUT: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`PHC_ASSERT_NEXT(a_out_one, clk, arst_n, done, !done)
	`PHC_ASSERT_IMPL(a_hit_get, clk, arst_n, done && hit, req_q.action == ACT_GET && !evicted)
	`PHC_ASSERT_IMPL(a_ev_set, clk, arst_n, done && evicted, req_q.action == ACT_SET)
endmodule
